// ----- sv/chs_pkg.sv -----
package chs_pkg;

    // fixed field widths
    localparam int KEY_W = 32;
    localparam int DIV_W = 11;
    localparam int CNT_W = $clog2(KEY_W);

    // default sizes of the bucket table and the node pool
    localparam int DEF_MAX_BUCKETS = 1024;
    localparam int DEF_POOL_NODES  = 4096;

    // reset value of the bucket count register
    localparam logic [DIV_W-1:0] BUCKET_COUNT_RST = DIV_W'(1024);

    // divisor that splits the magnitude into thousands and last three digits
    localparam logic [DIV_W-1:0] DIGIT_BLOCK = DIV_W'(1000);

    // reciprocal of the digit block, exact for every 32-bit magnitude
    localparam logic [KEY_W-1:0] DIGIT_RECIP = KEY_W'(274877907);
    localparam int               DIGIT_SHIFT = 38;

    // action codes
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_SEARCH = 1'b1;

    // input item
    typedef struct packed {
        logic                    action;
        logic signed [KEY_W-1:0] key;
    } chs_in_t;

    // result item
    typedef struct packed {
        logic             hit;
        logic [KEY_W-1:0] collision_total;
    } chs_out_t;

    // request into the divider
    typedef struct packed {
        logic             start;
        logic [KEY_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } chs_div_req_t;

    // answer from the divider
    typedef struct packed {
        logic             done;
        logic [KEY_W-1:0] quotient;
        logic [DIV_W-1:0] remainder;
    } chs_div_rsp_t;

    // operation handed to the table
    typedef struct packed {
        logic             start;
        logic             action;
        logic [KEY_W-1:0] key;
    } chs_tbl_req_t;

    // status coming back from the table
    typedef struct packed {
        logic             ready;
        logic             done;
        logic             hit;
        logic [KEY_W-1:0] collision_total;
    } chs_tbl_stat_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_HASH,
        S_TABLE,
        S_OUT
    } top_state_t;

    typedef enum logic [1:0] {
        H_IDLE,
        H_MUL,
        H_SUM,
        H_MOD
    } hash_state_t;

    typedef enum logic [2:0] {
        T_CLEAR,
        T_IDLE,
        T_HEAD,
        T_DECIDE,
        T_WALK,
        T_CHECK
    } tbl_state_t;

endpackage

// ----- sv/chs_divider.sv -----
module chs_divider
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  chs_pkg::chs_div_req_t req,
    output chs_pkg::chs_div_rsp_t rsp
);

    localparam int KW = chs_pkg::KEY_W;
    localparam int DW = chs_pkg::DIV_W;
    localparam int CW = chs_pkg::CNT_W;

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [KW-1:0] dvd_reg, dvd_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] dvs_reg, dvs_next;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          fits;

    // one restoring step per cycle, quotient shifts into the dividend register
    always_comb
    begin
        trial     = {rem_reg, dvd_reg[KW-1]};
        diff      = trial - {1'b0, dvs_reg};
        fits      = (trial >= {1'b0, dvs_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[KW-2:0], fits};
            rem_next = fits ? diff[DW-1:0] : trial[DW-1:0];
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(KW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // operands
    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = dvd_reg;
    assign rsp.remainder = rem_reg;

endmodule

// ----- sv/chs_hash.sv -----
module chs_hash
#(
    parameter int MAX_BUCKETS = chs_pkg::DEF_MAX_BUCKETS
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [chs_pkg::KEY_W-1:0]   key,
    input  logic [chs_pkg::DIV_W-1:0]          bucket_count,
    output logic                               done,
    output logic [((MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1)-1:0] bucket
);

    localparam int KW    = chs_pkg::KEY_W;
    localparam int DW    = chs_pkg::DIV_W;
    localparam int BKT_W = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;

    chs_pkg::hash_state_t  state_reg, state_next;
    chs_pkg::chs_div_req_t div_req;
    chs_pkg::chs_div_rsp_t div_rsp;

    logic             done_reg, done_next;
    logic [BKT_W-1:0] bucket_reg, bucket_next;
    logic [KW-1:0]    mag_reg, mag_next;
    logic [KW-1:0]    quot_reg, quot_next;
    logic [KW-1:0]    key_bits;
    logic [KW-1:0]    mag;
    logic [63:0]      prod;
    logic [KW-1:0]    digit_sum;
    logic [DW-1:0]    mod_eff;

    chs_divider u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // magnitude, most negative key wraps to 2^31 unsigned
    assign key_bits = key;
    assign mag      = key_bits[KW-1] ? (~key_bits + KW'(1)) : key_bits;

    // thousands part by reciprocal multiplication
    assign prod = 64'(mag_reg) * 64'(chs_pkg::DIGIT_RECIP);

    // q + (m - 1000 q) folds to m - 999 q
    assign digit_sum = mag_reg - quot_reg * KW'(chs_pkg::DIGIT_BLOCK - DW'(1));

    // modulus in use: zero acts as one, clamp to table size
    always_comb
    begin
        if (bucket_count == '0)
            mod_eff = DW'(1);
        else if (32'(bucket_count) > 32'(MAX_BUCKETS))
            mod_eff = DW'(MAX_BUCKETS);
        else
            mod_eff = bucket_count;
    end

    // split by 1000, then one pass through the divider by the bucket count
    always_comb
    begin
        state_next       = state_reg;
        done_next        = 1'b0;
        bucket_next      = bucket_reg;
        mag_next         = mag_reg;
        quot_next        = quot_reg;
        div_req.start    = 1'b0;
        div_req.dividend = digit_sum;
        div_req.divisor  = mod_eff;
        unique case (state_reg)
            chs_pkg::H_IDLE:
            begin
                if (start)
                begin
                    mag_next   = mag;
                    state_next = chs_pkg::H_MUL;
                end
            end
            chs_pkg::H_MUL:
            begin
                quot_next  = KW'(prod >> chs_pkg::DIGIT_SHIFT);
                state_next = chs_pkg::H_SUM;
            end
            chs_pkg::H_SUM:
            begin
                div_req.start = 1'b1;
                state_next    = chs_pkg::H_MOD;
            end
            chs_pkg::H_MOD:
            begin
                if (div_rsp.done)
                begin
                    bucket_next = BKT_W'(div_rsp.remainder);
                    done_next   = 1'b1;
                    state_next  = chs_pkg::H_IDLE;
                end
            end
            default:
            begin
                state_next = chs_pkg::H_IDLE;
            end
        endcase
    end

    // state and done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= chs_pkg::H_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // magnitude, quotient and bucket index
    always_ff @(posedge clk)
    begin
        mag_reg    <= mag_next;
        quot_reg   <= quot_next;
        bucket_reg <= bucket_next;
    end

    assign done   = done_reg;
    assign bucket = bucket_reg;

endmodule

// ----- sv/chs_table.sv -----
module chs_table
#(
    parameter int MAX_BUCKETS = chs_pkg::DEF_MAX_BUCKETS,
    parameter int POOL_NODES  = chs_pkg::DEF_POOL_NODES
)
(
    input  logic                                                     clk,
    input  logic                                                     rst_n,
    input  chs_pkg::chs_tbl_req_t                                    req,
    input  logic [((MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1)-1:0] bucket,
    output chs_pkg::chs_tbl_stat_t                                   stat
);

    localparam int KW     = chs_pkg::KEY_W;
    localparam int BKT_W  = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int NODE_W = $clog2(POOL_NODES + 1);
    localparam int NIDX_W = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;

    chs_pkg::tbl_state_t state_reg, state_next;

    logic [BKT_W-1:0]  clr_reg, clr_next;
    logic [BKT_W-1:0]  bucket_reg, bucket_next;
    logic              action_reg, action_next;
    logic [KW-1:0]     key_reg, key_next;
    logic [NODE_W-1:0] cur_reg, cur_next;
    logic [NODE_W-1:0] steps_reg, steps_next;
    logic [NODE_W-1:0] nodes_used_reg, nodes_used_next;
    logic [KW-1:0]     coll_reg, coll_next;
    logic              done_reg, done_next;
    logic              hit_reg, hit_next;

    // bucket heads: node index plus one, zero is an empty bucket
    logic [NODE_W-1:0] head_mem [MAX_BUCKETS];
    logic [NODE_W-1:0] head_q;
    logic              head_we;
    logic [BKT_W-1:0]  head_waddr;
    logic [NODE_W-1:0] head_wdata;

    // node pool
    logic [KW-1:0]     node_key_mem  [POOL_NODES];
    logic [NODE_W-1:0] node_link_mem [POOL_NODES];
    logic [KW-1:0]     node_key_q;
    logic [NODE_W-1:0] node_link_q;
    logic              node_we;
    logic [NIDX_W-1:0] node_waddr;
    logic [NIDX_W-1:0] node_raddr;

    assign node_waddr = NIDX_W'(nodes_used_reg);
    assign node_raddr = NIDX_W'(cur_reg - NODE_W'(1));

    // sequencer: clearing pass, then one insert or chain walk per item
    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        bucket_next     = bucket_reg;
        action_next     = action_reg;
        key_next        = key_reg;
        cur_next        = cur_reg;
        steps_next      = steps_reg;
        nodes_used_next = nodes_used_reg;
        coll_next       = coll_reg;
        done_next       = 1'b0;
        hit_next        = hit_reg;
        head_we         = 1'b0;
        head_waddr      = bucket_reg;
        head_wdata      = NODE_W'(nodes_used_reg + NODE_W'(1));
        node_we         = 1'b0;
        unique case (state_reg)
            chs_pkg::T_CLEAR:
            begin
                head_we    = 1'b1;
                head_waddr = clr_reg;
                head_wdata = '0;
                clr_next   = clr_reg + BKT_W'(1);
                if (clr_reg == BKT_W'(MAX_BUCKETS - 1))
                    state_next = chs_pkg::T_IDLE;
            end
            chs_pkg::T_IDLE:
            begin
                if (req.start)
                begin
                    bucket_next = bucket;
                    action_next = req.action;
                    key_next    = req.key;
                    state_next  = chs_pkg::T_HEAD;
                end
            end
            chs_pkg::T_HEAD:
            begin
                state_next = chs_pkg::T_DECIDE;
            end
            chs_pkg::T_DECIDE:
            begin
                if (action_reg == chs_pkg::ACT_INSERT)
                begin
                    if (head_q != '0 && coll_reg != '1)
                        coll_next = coll_reg + KW'(1);
                    hit_next = 1'b0;
                    if (32'(nodes_used_reg) < 32'(POOL_NODES))
                    begin
                        node_we         = 1'b1;
                        head_we         = 1'b1;
                        nodes_used_next = nodes_used_reg + NODE_W'(1);
                        hit_next        = 1'b1;
                    end
                    done_next  = 1'b1;
                    state_next = chs_pkg::T_IDLE;
                end
                else if (head_q == '0 || 32'(head_q) > 32'(POOL_NODES))
                begin
                    hit_next   = 1'b0;
                    done_next  = 1'b1;
                    state_next = chs_pkg::T_IDLE;
                end
                else
                begin
                    cur_next   = head_q;
                    steps_next = '0;
                    state_next = chs_pkg::T_WALK;
                end
            end
            chs_pkg::T_WALK:
            begin
                state_next = chs_pkg::T_CHECK;
            end
            chs_pkg::T_CHECK:
            begin
                steps_next = steps_reg + NODE_W'(1);
                cur_next   = node_link_q;
                if (node_key_q == key_reg)
                begin
                    hit_next   = 1'b1;
                    done_next  = 1'b1;
                    state_next = chs_pkg::T_IDLE;
                end
                else if (node_link_q == '0 || 32'(node_link_q) > 32'(POOL_NODES)
                         || 32'(steps_reg) + 32'd1 == 32'(POOL_NODES))
                begin
                    hit_next   = 1'b0;
                    done_next  = 1'b1;
                    state_next = chs_pkg::T_IDLE;
                end
                else
                begin
                    state_next = chs_pkg::T_WALK;
                end
            end
            default:
            begin
                state_next = chs_pkg::T_CLEAR;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= chs_pkg::T_CLEAR;
            clr_reg        <= '0;
            nodes_used_reg <= '0;
            coll_reg       <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            nodes_used_reg <= nodes_used_next;
            coll_reg       <= coll_next;
            done_reg       <= done_next;
        end
    end

    // item payload and walk pointer
    always_ff @(posedge clk)
    begin
        bucket_reg <= bucket_next;
        action_reg <= action_next;
        key_reg    <= key_next;
        cur_reg    <= cur_next;
        steps_reg  <= steps_next;
        hit_reg    <= hit_next;
    end

    // bucket head memory, registered read
    always_ff @(posedge clk)
    begin
        if (head_we)
            head_mem[head_waddr] <= head_wdata;
        head_q <= head_mem[bucket_reg];
    end

    // node memories, registered read
    always_ff @(posedge clk)
    begin
        if (node_we)
        begin
            node_key_mem[node_waddr]  <= key_reg;
            node_link_mem[node_waddr] <= head_q;
        end
        node_key_q  <= node_key_mem[node_raddr];
        node_link_q <= node_link_mem[node_raddr];
    end

    assign stat.ready           = (state_reg != chs_pkg::T_CLEAR);
    assign stat.done            = done_reg;
    assign stat.hit             = hit_reg;
    assign stat.collision_total = coll_reg;

    // pool allocation never runs past the pool
    a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(nodes_used_reg) <= 32'(POOL_NODES))
        else $error("node pool count beyond pool size");

    // a walk only visits real nodes
    a_walk_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == chs_pkg::T_WALK |-> cur_reg != '0)
        else $error("chain walk on empty link");

    // result is only reported once the sequencer is back at rest
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> state_reg == chs_pkg::T_IDLE)
        else $error("table done outside idle");

endmodule

// ----- sv/chained_hash_set_engine_unit.sv -----
// Hash set of signed 32-bit keys with separate chaining.
// req channel: req_valid / req_stall with req_item {action, key}; action 0 inserts
// the key, 1 searches for it. rsp channel: rsp_valid / rsp_stall with rsp_item
// {hit, collision_total}, one result item per request item, in order.
// cfg channel: cfg_valid / cfg_ready with cfg_data, the bucket count (reset 1024);
// write it only while no item is in flight.
// An item splits its magnitude into thousands and last three digits by a reciprocal
// multiply, then one bit-serial divider reduces the digit sum by the bucket count,
// then the table sequencer reads the bucket head.
// The hash steps are H_MUL, H_SUM and H_MOD; the table steps are T_HEAD and T_DECIDE,
// and a search adds T_WALK and T_CHECK for each chain node it visits. One item is in
// work at a time; req_stall is high from accept until the result has moved into the
// output register.
// After reset the bucket heads are cleared, one per cycle, across all MAX_BUCKETS entries,
// and req_stall stays high meanwhile; cfg writes are taken at any time.
// A held result waits in the output register while rsp_stall is high; the next
// item may be accepted and worked on, and only its result hand-off waits.
module chained_hash_set_engine_unit
#(
    parameter int MAX_BUCKETS = chs_pkg::DEF_MAX_BUCKETS,
    parameter int POOL_NODES  = chs_pkg::DEF_POOL_NODES
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    output logic                       req_stall,
    input  chs_pkg::chs_in_t           req_item,
    output logic                       rsp_valid,
    input  logic                       rsp_stall,
    output chs_pkg::chs_out_t          rsp_item,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [chs_pkg::DIV_W-1:0]  cfg_data
);

    localparam int BKT_W = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int KW    = chs_pkg::KEY_W;

    chs_pkg::top_state_t    state_reg, state_next;
    chs_pkg::chs_tbl_req_t  tbl_req;
    chs_pkg::chs_tbl_stat_t tbl_stat;
    chs_pkg::chs_in_t       item_reg, item_next;
    chs_pkg::chs_out_t      rsp_item_reg, rsp_item_next;

    logic                      rsp_valid_reg, rsp_valid_next;
    logic                      res_hit_reg, res_hit_next;
    logic [KW-1:0]             res_coll_reg, res_coll_next;
    logic [chs_pkg::DIV_W-1:0] bucket_count_reg;
    logic                      accept;
    logic                      hash_done;
    logic [BKT_W-1:0]          hash_bucket;

    chs_hash #(
        .MAX_BUCKETS (MAX_BUCKETS)
    ) u_hash (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (accept),
        .key          (req_item.key),
        .bucket_count (bucket_count_reg),
        .done         (hash_done),
        .bucket       (hash_bucket)
    );

    chs_table #(
        .MAX_BUCKETS (MAX_BUCKETS),
        .POOL_NODES  (POOL_NODES)
    ) u_table (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (tbl_req),
        .bucket (hash_bucket),
        .stat   (tbl_stat)
    );

    // input handshake
    assign req_stall = !(state_reg == chs_pkg::S_IDLE && tbl_stat.ready);
    assign accept    = req_valid && !req_stall;
    assign cfg_ready = 1'b1;

    // item sequencing and result hand-off
    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        res_hit_next   = res_hit_reg;
        res_coll_next  = res_coll_reg;
        rsp_item_next  = rsp_item_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        tbl_req.start  = 1'b0;
        tbl_req.action = item_reg.action;
        tbl_req.key    = item_reg.key;
        unique case (state_reg)
            chs_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    item_next  = req_item;
                    state_next = chs_pkg::S_HASH;
                end
            end
            chs_pkg::S_HASH:
            begin
                if (hash_done)
                begin
                    tbl_req.start = 1'b1;
                    state_next    = chs_pkg::S_TABLE;
                end
            end
            chs_pkg::S_TABLE:
            begin
                if (tbl_stat.done)
                begin
                    res_hit_next  = tbl_stat.hit;
                    res_coll_next = tbl_stat.collision_total;
                    state_next    = chs_pkg::S_OUT;
                end
            end
            chs_pkg::S_OUT:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_item_next.hit             = res_hit_reg;
                    rsp_item_next.collision_total = res_coll_reg;
                    rsp_valid_next                = 1'b1;
                    state_next                    = chs_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = chs_pkg::S_IDLE;
            end
        endcase
    end

    // control state and config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= chs_pkg::S_IDLE;
            rsp_valid_reg    <= 1'b0;
            bucket_count_reg <= chs_pkg::BUCKET_COUNT_RST;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_valid && cfg_ready)
                bucket_count_reg <= cfg_data;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        res_hit_reg  <= res_hit_next;
        res_coll_reg <= res_coll_next;
        rsp_item_reg <= rsp_item_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

    // the hash unit only finishes for an item that is waiting on it
    a_hash_phase: assert property (@(posedge clk) disable iff (!rst_n)
        hash_done |-> state_reg == chs_pkg::S_HASH)
        else $error("hash done outside hash phase");

    // the table only finishes for an item that is waiting on it
    a_table_phase: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_stat.done |-> state_reg == chs_pkg::S_TABLE)
        else $error("table done outside table phase");

    // a finished item waits while the held result is stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == chs_pkg::S_OUT && rsp_valid_reg && rsp_stall
        |=> state_reg == chs_pkg::S_OUT)
        else $error("result hand-off overran a stalled result");

endmodule
